### sv/srb_pkg.sv
// ----------------------------------------------------------------------------
// srb_pkg: shared types and constants of the sequence reorder buffer
// Window depth, field widths, status and request codes, register indexes,
// and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package srb_pkg;

  // Reorder window depth; slot of a packet is its sequence number mod depth.
  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);

  // Field widths.
  localparam int SEQ_W    = 16;
  localparam int ID_W     = 16;
  localparam int HANDLE_W = 16;
  localparam int TYPE_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Highest sequence number before it wraps to zero.
  localparam logic [SEQ_W-1:0] SEQ_MAX = 16'hffff;

  // Reciprocal for seq mod DEPTH: floor(seq / DEPTH) = (seq * RECIP) >> MOD_SHIFT.
  localparam int MOD_SHIFT = SEQ_W + IDX_W;
  localparam int RECIP     = ((1 << MOD_SHIFT) + DEPTH - 1) / DEPTH;
  localparam int RECIP_W   = SEQ_W + 1;
  localparam int PROD_W    = SEQ_W + RECIP_W;
  localparam int QD_W      = SEQ_W + IDX_W;

  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [SEQ_W-1:0]    seq_t;
  typedef logic [HANDLE_W-1:0] handle_t;

  // Request kinds; kind three is handled as an other data packet.
  localparam logic [TYPE_W-1:0] REQ_SINGLE    = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_OTHER     = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_HEARTBEAT = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PEER_ID    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PEER_PORT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINK_READY = 2'd2;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_RELEASED   = 3'd0,
    ST_STORED     = 3'd1,
    ST_WRONG_PEER = 3'd2,
    ST_DROP_INIT  = 3'd3,
    ST_OVERFLOW   = 3'd4,
    ST_HEARTBEAT  = 3'd5
  } status_t;

  // One input request.
  typedef struct packed {
    logic [ID_W-1:0]   sender_id;
    logic [ID_W-1:0]   source_port;
    seq_t              seq_number;
    logic [TYPE_W-1:0] req_type;
    handle_t           packet_handle;
  } pkt_t;

  // One result.
  typedef struct packed {
    status_t status;
    handle_t out_handle;
    logic    conn_alive;
    logic    last_result;
  } res_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_pkt;
    logic eval_fire;
    logic drain_fire;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic out_free;
    logic eval_more;
    logic drain_more;
  } stat_t;

endpackage

### sv/srb_if.sv
// ----------------------------------------------------------------------------
// srb_if: request and result channel interfaces
// Valid/ready channels carrying one request or one result per transfer.
// ----------------------------------------------------------------------------
interface srb_in_if;
  logic                         valid;
  logic                         ready;
  logic [srb_pkg::ID_W-1:0]     sender_id;
  logic [srb_pkg::ID_W-1:0]     source_port;
  logic [srb_pkg::SEQ_W-1:0]    seq_number;
  logic [srb_pkg::TYPE_W-1:0]   req_type;
  logic [srb_pkg::HANDLE_W-1:0] packet_handle;

  modport source(output valid, sender_id, source_port, seq_number, req_type,
                 packet_handle, input ready);
  modport sink(input valid, sender_id, source_port, seq_number, req_type,
               packet_handle, output ready);
endinterface

interface srb_out_if;
  logic                         valid;
  logic                         ready;
  logic [2:0]                   status;
  logic [srb_pkg::HANDLE_W-1:0] out_handle;
  logic                         conn_alive;
  logic                         last_result;

  modport source(output valid, status, out_handle, conn_alive, last_result,
                 input ready);
  modport sink(input valid, status, out_handle, conn_alive, last_result,
               output ready);
endinterface

### sv/srb_ram.sv
// ----------------------------------------------------------------------------
// srb_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module srb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and read through a registered output.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/srb_ctrl.sv
// ----------------------------------------------------------------------------
// srb_ctrl: request sequencer of the reorder buffer
// Takes a request, evaluates it, then walks the drain of any stored slots.
// ----------------------------------------------------------------------------
module srb_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  srb_pkg::stat_t stat,
  output srb_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EVAL  = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Commands follow the state and the output register's room.
  always_comb begin
    in_ready       = (state_r == S_IDLE);
    cmd.load_pkt   = (state_r == S_IDLE) && in_valid;
    cmd.eval_fire  = (state_r == S_EVAL) && stat.out_free;
    cmd.drain_fire = (state_r == S_DRAIN) && stat.out_free;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (stat.out_free) state_nxt = stat.eval_more ? S_DRAIN : S_IDLE;
      end
      S_DRAIN: begin
        if (stat.out_free && !stat.drain_more) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### sv/srb_dp.sv
// ----------------------------------------------------------------------------
// srb_dp: datapath of the reorder buffer
// Configuration, expected sequence, slot valid bits, handle RAM, slot index
// unit and the result register.
// ----------------------------------------------------------------------------
module srb_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [srb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [srb_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  srb_pkg::pkt_t                      in_pkt,
  input  srb_pkg::cmd_t                      cmd,
  output srb_pkg::stat_t                     stat,
  input  logic                               out_ready,
  output logic                               out_valid,
  output srb_pkg::res_t                      out_res
);

  logic [srb_pkg::ID_W-1:0] peer_id_r, peer_port_r;
  logic                     link_ready_r;

  srb_pkg::pkt_t               pkt_r;
  logic [srb_pkg::PROD_W-1:0]  prod_r;

  srb_pkg::seq_t               expected_r, expected_nxt;
  srb_pkg::idx_t               exp_idx_r, exp_idx_nxt, idx_inc;
  logic [srb_pkg::DEPTH-1:0]   valid_r;

  logic                        out_valid_r;
  srb_pkg::res_t               res_r;

  srb_pkg::seq_t               quot, rem;
  logic [srb_pkg::QD_W-1:0]    quot_x;
  srb_pkg::idx_t               seq_idx;
  srb_pkg::handle_t            ram_rdata;

  logic          ev_release, ev_store, ev_more, valid_inc, advance;
  srb_pkg::res_t ev_res, dr_res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peer_id_r    <= '0;
      peer_port_r  <= '0;
      link_ready_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        srb_pkg::CFG_PEER_ID:    peer_id_r    <= cfg_data;
        srb_pkg::CFG_PEER_PORT:  peer_port_r  <= cfg_data;
        srb_pkg::CFG_LINK_READY: link_ready_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Capture the request and start the slot index by reciprocal multiply.
  always_ff @(posedge clk) begin
    if (cmd.load_pkt) begin
      pkt_r  <= in_pkt;
      prod_r <= srb_pkg::PROD_W'(in_pkt.seq_number) * srb_pkg::PROD_W'(srb_pkg::RECIP);
    end
  end

  // Finish seq mod DEPTH: remainder after the quotient, with one correction.
  always_comb begin
    quot   = srb_pkg::SEQ_W'(prod_r[srb_pkg::PROD_W-1:srb_pkg::MOD_SHIFT]);
    quot_x = srb_pkg::QD_W'(quot) * srb_pkg::QD_W'(srb_pkg::DEPTH);
    rem    = pkt_r.seq_number - quot_x[srb_pkg::SEQ_W-1:0];
    if (rem >= srb_pkg::SEQ_W'(srb_pkg::DEPTH)) begin
      seq_idx = srb_pkg::idx_t'(rem - srb_pkg::SEQ_W'(srb_pkg::DEPTH));
    end else begin
      seq_idx = srb_pkg::idx_t'(rem);
    end
  end

  // Slot of the next expected sequence; it restarts at zero on sequence wrap.
  always_comb begin
    if (expected_r == srb_pkg::SEQ_MAX ||
        exp_idx_r == srb_pkg::idx_t'(srb_pkg::DEPTH - 1)) begin
      idx_inc = '0;
    end else begin
      idx_inc = exp_idx_r + 1'b1;
    end
    valid_inc = valid_r[idx_inc];
  end

  // Decision for a newly evaluated request.
  always_comb begin
    ev_release = 1'b0;
    ev_store   = 1'b0;
    ev_more    = 1'b0;
    ev_res.status      = srb_pkg::ST_WRONG_PEER;
    ev_res.out_handle  = pkt_r.packet_handle;
    ev_res.conn_alive  = 1'b0;
    ev_res.last_result = 1'b1;
    priority if (pkt_r.sender_id != peer_id_r || pkt_r.source_port != peer_port_r) begin
      ev_res.status = srb_pkg::ST_WRONG_PEER;
    end else if (pkt_r.req_type == srb_pkg::REQ_HEARTBEAT) begin
      ev_res.status     = srb_pkg::ST_HEARTBEAT;
      ev_res.conn_alive = 1'b1;
    end else if (!link_ready_r) begin
      // Init mode: only a single packet with sequence zero goes through.
      if (pkt_r.seq_number == '0 && pkt_r.req_type == srb_pkg::REQ_SINGLE) begin
        ev_res.status = srb_pkg::ST_RELEASED;
        ev_release    = 1'b1;
      end else begin
        ev_res.status = srb_pkg::ST_DROP_INIT;
      end
    end else if (pkt_r.seq_number == expected_r) begin
      ev_res.status      = srb_pkg::ST_RELEASED;
      ev_res.conn_alive  = 1'b1;
      ev_release         = 1'b1;
      ev_more            = valid_inc;
      ev_res.last_result = !valid_inc;
    end else if (valid_r[seq_idx]) begin
      ev_res.status     = srb_pkg::ST_OVERFLOW;
      ev_res.conn_alive = 1'b1;
    end else begin
      ev_res.status     = srb_pkg::ST_STORED;
      ev_res.conn_alive = 1'b1;
      ev_store          = 1'b1;
    end
  end

  // Result of one drain step from the slot at the expected sequence.
  always_comb begin
    dr_res.status      = srb_pkg::ST_RELEASED;
    dr_res.out_handle  = ram_rdata;
    dr_res.conn_alive  = 1'b1;
    dr_res.last_result = !valid_inc;
  end

  // Expected sequence advances on every release.
  always_comb begin
    advance      = (cmd.eval_fire && ev_release) || cmd.drain_fire;
    expected_nxt = advance ? expected_r + 1'b1 : expected_r;
    exp_idx_nxt  = advance ? idx_inc : exp_idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_r <= '0;
      exp_idx_r  <= '0;
    end else begin
      expected_r <= expected_nxt;
      exp_idx_r  <= exp_idx_nxt;
    end
  end

  // Slot valid bits: set on store, cleared on drain.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (cmd.eval_fire && ev_store) valid_r[seq_idx] <= 1'b1;
      if (cmd.drain_fire)            valid_r[exp_idx_r] <= 1'b0;
    end
  end

  // Handle store; read data is registered from the next expected slot.
  srb_ram #(
    .WIDTH(srb_pkg::HANDLE_W),
    .DEPTH(srb_pkg::DEPTH)
  ) u_handle_ram (
    .clk  (clk),
    .we   (cmd.eval_fire && ev_store),
    .waddr(seq_idx),
    .wdata(pkt_r.packet_handle),
    .raddr(exp_idx_nxt),
    .rdata(ram_rdata)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.eval_fire || cmd.drain_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval_fire) begin
      res_r <= ev_res;
    end else if (cmd.drain_fire) begin
      res_r <= dr_res;
    end
  end

  always_comb begin
    stat.out_free   = !out_valid_r || out_ready;
    stat.eval_more  = ev_more;
    stat.drain_more = valid_inc;
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule

### sv/sequence_reorder_buffer_core.sv
// ----------------------------------------------------------------------------
// sequence_reorder_buffer_core: receive reorder window for one connection
// Flow: a request is registered on acceptance and evaluated from that
// register into the result register; each drained stored slot adds one
// more result, its handle read from the handle RAM's registered port. A
// new request is taken only once the last result of the previous one has
// entered the result register. Reset clears configuration, expected
// sequence and all slot valid bits directly; there is no clearing pass.
// ----------------------------------------------------------------------------
module sequence_reorder_buffer_core (
  input  logic                           clk,
  input  logic                           rst_n,
  srb_in_if.sink                         in_ch,
  srb_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [srb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [srb_pkg::CFG_DATA_W-1:0] cfg_data
);

  srb_pkg::pkt_t  in_pkt;
  srb_pkg::res_t  out_res;
  srb_pkg::cmd_t  cmd;
  srb_pkg::stat_t stat;
  logic           in_ready, out_valid;

  // Gather the request fields.
  always_comb begin
    in_pkt.sender_id     = in_ch.sender_id;
    in_pkt.source_port   = in_ch.source_port;
    in_pkt.seq_number    = in_ch.seq_number;
    in_pkt.req_type      = in_ch.req_type;
    in_pkt.packet_handle = in_ch.packet_handle;
  end

  srb_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  srb_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_pkt   (in_pkt),
    .cmd      (cmd),
    .stat     (stat),
    .out_ready(out_ch.ready),
    .out_valid(out_valid),
    .out_res  (out_res)
  );

  // Drive the channels.
  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid;
  assign out_ch.status      = out_res.status;
  assign out_ch.out_handle  = out_res.out_handle;
  assign out_ch.conn_alive  = out_res.conn_alive;
  assign out_ch.last_result = out_res.last_result;

endmodule

### sv/srb_checker.sv
// ----------------------------------------------------------------------------
// srb_checker: port-level assertions of the reorder buffer
// Watches the top-level channels and checks result ordering rules.
// ----------------------------------------------------------------------------
module srb_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [2:0]                   status,
  input logic [srb_pkg::HANDLE_W-1:0] out_handle,
  input logic                         conn_alive,
  input logic                         last_result
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_handle)
      && $stable(conn_alive) && $stable(last_result))
    else $error("stalled result changed");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // No new request is taken while a drain still has results to give.
  a_no_take_mid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !last_result |-> !in_ready)
    else $error("request taken during drain");

  // Only releases are followed by further results of the same request.
  a_single_non_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != srb_pkg::ST_RELEASED |-> last_result)
    else $error("non-release result is not the last one");

  // Wrong-peer and init drops never mark the connection alive.
  a_drop_not_alive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == srb_pkg::ST_WRONG_PEER || status == srb_pkg::ST_DROP_INIT)
      |-> !conn_alive)
    else $error("dropped request marked connection alive");

endmodule

bind sequence_reorder_buffer_core srb_checker u_srb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .status     (out_ch.status),
  .out_handle (out_ch.out_handle),
  .conn_alive (out_ch.conn_alive),
  .last_result(out_ch.last_result)
);

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the sequence reorder buffer core
// Sends packet requests in random bursts and gaps and stalls the result side.
// A window model in the bench predicts every result, and each result is
// compared in order against that prediction. The run covers init mode, peer
// filtering, heartbeats, stores, overflow drops, full-window drains, a long
// receiver hold-off and shuffled random windows.
// ----------------------------------------------------------------------------
module tb_top;
  import srb_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int MAX_REPORTS   = 200;

  // Kind three is not named in the package; the block treats it as other data.
  localparam logic [TYPE_W-1:0] REQ_KIND3 = 2'd3;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  srb_in_if  in_ch ();
  srb_out_if out_ch ();

  sequence_reorder_buffer_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Window model state, updated at every accepted request and register write.
  logic [ID_W-1:0] win_peer_id;
  logic [ID_W-1:0] win_peer_port;
  logic            win_link_ready;
  seq_t            win_next_seq;
  logic            win_slot_full [DEPTH];
  handle_t         win_slot_tag  [DEPTH];
  res_t            results_due [$];
  res_t            want_res;

  // Stimulus state.
  logic [ID_W-1:0] gen_id   = '0;
  logic [ID_W-1:0] gen_port = '0;
  logic            gen_link = 1'b0;
  seq_t            gen_base = '0;
  int              burst_left = 0;
  bit              pace_fast = 1'b0;
  bit              rx_fast   = 1'b0;
  bit              hold_req  = 1'b0;

  // Run statistics.
  int requests_sent = 0;
  int results_seen  = 0;
  int mismatches    = 0;
  int overflow_drops = 0;
  int longest_drain = 0;
  int wrap_count    = 0;
  int holds_done    = 0;
  int cycle_count   = 0;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic res_t mk_res(status_t st, handle_t h, logic alive);
    res_t r;
    r.status      = st;
    r.out_handle  = h;
    r.conn_alive  = alive;
    r.last_result = 1'b0;
    return r;
  endfunction

  function automatic pkt_t make_pkt(logic [ID_W-1:0] sid, logic [ID_W-1:0] port,
                                    seq_t seq, logic [TYPE_W-1:0] kind, handle_t h);
    pkt_t p;
    p.sender_id     = sid;
    p.source_port   = port;
    p.seq_number    = seq;
    p.req_type      = kind;
    p.packet_handle = h;
    return p;
  endfunction

  function automatic pkt_t peer_pkt(seq_t seq, logic [TYPE_W-1:0] kind, handle_t h);
    return make_pkt(gen_id, gen_port, seq, kind, h);
  endfunction

  // A packet whose sender, port or both differ from the configured peer.
  function automatic pkt_t stranger_pkt();
    logic [ID_W-1:0] sid;
    logic [ID_W-1:0] port;
    sid  = gen_id;
    port = gen_port;
    case ($urandom_range(0, 2))
      0: sid = gen_id ^ ID_W'($urandom_range(1, 16'hffff));
      1: port = gen_port ^ ID_W'($urandom_range(1, 16'hffff));
      default: begin
        sid  = ID_W'($urandom);
        port = gen_port ^ ID_W'($urandom_range(1, 16'hffff));
      end
    endcase
    return make_pkt(sid, port, seq_t'($urandom), TYPE_W'($urandom_range(0, 3)),
                    handle_t'($urandom));
  endfunction

  function automatic logic [TYPE_W-1:0] data_kind();
    case ($urandom_range(0, 2))
      0:       return REQ_SINGLE;
      1:       return REQ_OTHER;
      default: return REQ_KIND3;
    endcase
  endfunction

  // Work out the results of one accepted request and advance the window.
  function automatic void window_accept(pkt_t p);
    res_t batch [$];
    idx_t pos;
    seq_t old_seq;
    old_seq = win_next_seq;
    if (p.sender_id != win_peer_id || p.source_port != win_peer_port) begin
      batch.push_back(mk_res(ST_WRONG_PEER, p.packet_handle, 1'b0));
    end else if (p.req_type == REQ_HEARTBEAT) begin
      batch.push_back(mk_res(ST_HEARTBEAT, p.packet_handle, 1'b1));
    end else if (!win_link_ready) begin
      // Init mode lets only a sequence-zero single packet through.
      if (p.seq_number == '0 && p.req_type == REQ_SINGLE) begin
        batch.push_back(mk_res(ST_RELEASED, p.packet_handle, 1'b0));
        win_next_seq = win_next_seq + 1'b1;
      end else begin
        batch.push_back(mk_res(ST_DROP_INIT, p.packet_handle, 1'b0));
      end
    end else if (p.seq_number == win_next_seq) begin
      // In-order release, then drain consecutive stored slots.
      batch.push_back(mk_res(ST_RELEASED, p.packet_handle, 1'b1));
      win_next_seq = win_next_seq + 1'b1;
      pos = idx_t'(win_next_seq % DEPTH);
      while (win_slot_full[pos] && batch.size() <= DEPTH) begin
        batch.push_back(mk_res(ST_RELEASED, win_slot_tag[pos], 1'b1));
        win_slot_full[pos] = 1'b0;
        win_next_seq = win_next_seq + 1'b1;
        pos = idx_t'(win_next_seq % DEPTH);
      end
      if (batch.size() - 1 > longest_drain) longest_drain = batch.size() - 1;
      if (win_next_seq < old_seq) wrap_count++;
    end else begin
      pos = idx_t'(p.seq_number % DEPTH);
      if (win_slot_full[pos]) begin
        batch.push_back(mk_res(ST_OVERFLOW, p.packet_handle, 1'b1));
        overflow_drops++;
      end else begin
        win_slot_full[pos] = 1'b1;
        win_slot_tag[pos]  = p.packet_handle;
        batch.push_back(mk_res(ST_STORED, p.packet_handle, 1'b1));
      end
    end
    batch[batch.size() - 1].last_result = 1'b1;
    foreach (batch[i]) results_due.push_back(batch[i]);
  endfunction

  // Track register writes and accepted requests in the window model.
  always @(posedge clk) begin
    if (!rst_n) begin
      win_peer_id    = '0;
      win_peer_port  = '0;
      win_link_ready = 1'b0;
      win_next_seq   = '0;
      foreach (win_slot_full[i]) win_slot_full[i] = 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PEER_ID:    win_peer_id    = cfg_data;
          CFG_PEER_PORT:  win_peer_port  = cfg_data;
          CFG_LINK_READY: win_link_ready = cfg_data[0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        window_accept(make_pkt(in_ch.sender_id, in_ch.source_port, in_ch.seq_number,
                               in_ch.req_type, in_ch.packet_handle));
      end
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t unexpected result: expected none, got st %0d h %h a %0b l %0b",
                   $time, out_ch.status, out_ch.out_handle, out_ch.conn_alive,
                   out_ch.last_result);
      end else begin
        want_res = results_due.pop_front();
        if (out_ch.status !== want_res.status || out_ch.out_handle !== want_res.out_handle ||
            out_ch.conn_alive !== want_res.conn_alive ||
            out_ch.last_result !== want_res.last_result) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t mismatch: expected st %0d h %h a %0b l %0b, got st %0d h %h a %0b l %0b",
                     $time, want_res.status, want_res.out_handle, want_res.conn_alive,
                     want_res.last_result, out_ch.status, out_ch.out_handle,
                     out_ch.conn_alive, out_ch.last_result);
        end
      end
    end
  end

  // Result-side ready: a mode of its own that changes now and then, plus a
  // long hold-off on request.
  initial begin : result_sink
    int       rx_tick;
    int       mode_left;
    int       hold_left;
    rx_mode_t rx_mode;
    rx_tick   = 0;
    mode_left = 0;
    hold_left = 0;
    rx_mode   = RX_ALWAYS;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_tick++;
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (rx_fast || rx_mode == RX_ALWAYS) begin
        out_ch.ready <= 1'b1;
      end else if (rx_mode == RX_RANDOM) begin
        out_ch.ready <= ($urandom_range(0, 99) < 60);
      end else begin
        out_ch.ready <= ((rx_tick % 7) < 3);
      end
    end
  end

  // Watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d results outstanding", cycle_count,
             results_due.size());
    $display("FAIL");
    $finish;
  end

  // Offer one request and wait until it is accepted; bursts and gaps are
  // drawn here unless the fast pace is on.
  task automatic send_pkt(pkt_t p);
    int gap;
    if (!pace_fast && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    in_ch.valid         <= 1'b1;
    in_ch.sender_id     <= p.sender_id;
    in_ch.source_port   <= p.source_port;
    in_ch.seq_number    <= p.seq_number;
    in_ch.req_type      <= p.req_type;
    in_ch.packet_handle <= p.packet_handle;
    do @(posedge clk); while (!in_ch.ready);
    requests_sent++;
  endtask

  // Stop offering, wait for every predicted result, then let the block settle.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (results_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all three registers in back-to-back cycles; only called when idle.
  task automatic set_link(logic [ID_W-1:0] id, logic [ID_W-1:0] port, logic up);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PEER_ID;
    cfg_data  <= id;
    @(posedge clk);
    cfg_index <= CFG_PEER_PORT;
    cfg_data  <= port;
    @(posedge clk);
    cfg_index <= CFG_LINK_READY;
    cfg_data  <= CFG_DATA_W'(up);
    @(posedge clk);
    cfg_we   <= 1'b0;
    gen_id   = id;
    gen_port = port;
    gen_link = up;
  endtask

  // One noise request: heartbeat, stranger, random sequence or stale duplicate.
  task automatic send_noise(seq_t base);
    case ($urandom_range(0, 3))
      0: send_pkt(peer_pkt(seq_t'($urandom), REQ_HEARTBEAT, handle_t'($urandom)));
      1: send_pkt(stranger_pkt());
      2: send_pkt(peer_pkt(seq_t'($urandom), data_kind(), handle_t'($urandom)));
      default: send_pkt(peer_pkt(base - seq_t'($urandom_range(1, 40)), data_kind(),
                                 handle_t'($urandom)));
    endcase
  endtask

  // Send sequence numbers base .. base+count-1 in shuffled order, with some
  // noise in between and, at skip_pct, a request left out.
  task automatic send_window(seq_t base, int count, int noise_pct, int skip_pct);
    seq_t order [$];
    seq_t tmp;
    int   j;
    for (int i = 0; i < count; i++) order.push_back(base + seq_t'(i));
    for (int i = count - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    foreach (order[i]) begin
      if ($urandom_range(0, 99) < noise_pct) send_noise(base);
      if ($urandom_range(0, 99) >= skip_pct)
        send_pkt(peer_pkt(order[i], data_kind(), handle_t'($urandom)));
    end
  endtask

  // Reset values: peer 0/0, link in init mode.
  task automatic test_init_mode();
    send_pkt(make_pkt('0, '0, 16'hffff, REQ_HEARTBEAT, 16'hffff));
    send_pkt(make_pkt(16'hffff, '0, '0, REQ_SINGLE, 16'h0001));
    send_pkt(make_pkt('0, '0, '0, REQ_SINGLE, 16'h0000));
    send_pkt(make_pkt('0, '0, '0, REQ_OTHER, 16'h00ff));
    send_pkt(make_pkt('0, '0, '0, REQ_KIND3, 16'h5a5a));
    send_pkt(make_pkt('0, '0, 16'hffff, REQ_SINGLE, 16'ha5a5));
    wait_idle();
  endtask

  // All-ones peer with link ready: wrong port, store, overflow, release with drain.
  task automatic test_peer_extremes();
    set_link(16'hffff, 16'hffff, 1'b1);
    gen_base = win_next_seq;
    send_pkt(make_pkt(16'hffff, 16'h7fff, gen_base, REQ_SINGLE, 16'h1111));
    send_pkt(peer_pkt(gen_base + seq_t'(1), REQ_OTHER, 16'h2222));
    send_pkt(peer_pkt(gen_base + seq_t'(1 + DEPTH), REQ_SINGLE, 16'h3333));
    send_pkt(peer_pkt(gen_base, REQ_KIND3, 16'h4444));
    wait_idle();
  endtask

  // Fill every slot, the one of the expected number too, then release:
  // the drain stops after a full window.
  task automatic test_full_window();
    gen_base = win_next_seq;
    for (int i = DEPTH; i >= 1; i--)
      send_pkt(peer_pkt(gen_base + seq_t'(i), data_kind(), handle_t'($urandom)));
    send_pkt(peer_pkt(gen_base, REQ_SINGLE, handle_t'($urandom)));
    wait_idle();
  endtask

  // Two shuffled reorder windows with the link ready, the second with noise.
  task automatic test_shuffled_windows();
    gen_base = win_next_seq;
    send_window(gen_base, 14, 0, 0);
    gen_base = gen_base + seq_t'(14);
    send_window(gen_base, DEPTH, 10, 0);
    wait_idle();
  endtask

  // The receiver holds off for a long stretch while full-speed windows keep
  // coming, so the block fills and stalls its input.
  task automatic test_backpressure();
    hold_req  = 1'b1;
    pace_fast = 1'b1;
    gen_base  = win_next_seq;
    repeat (3) begin
      send_window(gen_base, DEPTH, 0, 0);
      gen_base = gen_base + seq_t'(DEPTH);
    end
    pace_fast = 1'b0;
    wait_idle();
  endtask

  // Mostly well-formed shuffled windows with random content, some noise and
  // dropped requests; every few rounds the block is reconfigured.
  task automatic test_random_traffic();
    int start_count;
    int rounds;
    int k;
    start_count = requests_sent;
    rounds = 0;
    while (requests_sent - start_count < 100) begin
      if (rounds % 5 == 0) begin
        wait_idle();
        case ($urandom_range(0, 3))
          0:       set_link('0, '0, ($urandom_range(0, 3) != 0));
          1:       set_link(16'hffff, 16'hffff, ($urandom_range(0, 3) != 0));
          default: set_link(ID_W'($urandom), ID_W'($urandom), ($urandom_range(0, 3) != 0));
        endcase
        gen_base = win_next_seq;
      end
      rounds++;
      if (gen_link) begin
        k = ($urandom_range(0, 5) == 0) ? DEPTH + 1 : $urandom_range(1, 12);
        send_window(gen_base, k, 10, 3);
        gen_base = gen_base + seq_t'(k);
      end else begin
        repeat ($urandom_range(4, 10)) begin
          case ($urandom_range(0, 3))
            0: send_pkt(peer_pkt('0, REQ_SINGLE, handle_t'($urandom)));
            1: send_pkt(peer_pkt('0, data_kind(), handle_t'($urandom)));
            2: send_noise(gen_base);
            default: send_pkt(peer_pkt(seq_t'($urandom), data_kind(), handle_t'($urandom)));
          endcase
        end
      end
    end
    wait_idle();
  endtask

  // Main sequence.
  initial begin
    int settle;
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= '0;
    cfg_data            <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.sender_id     <= '0;
    in_ch.source_port   <= '0;
    in_ch.seq_number    <= '0;
    in_ch.req_type      <= '0;
    in_ch.packet_handle <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_init_mode();
    test_peer_extremes();
    test_full_window();
    test_shuffled_windows();
    test_backpressure();
    test_random_traffic();

    // Bounded final wait; anything still predicted counts as missing.
    in_ch.valid <= 1'b0;
    settle = 0;
    while (results_due.size() != 0 && settle < 5000) begin
      @(posedge clk);
      settle++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (results_due.size() != 0) begin
      $display("%0t %0d predicted results never arrived", $time, results_due.size());
      mismatches += results_due.size();
    end

    $display("Sent %0d requests, checked %0d results, %0d mismatches, %0d cycles",
             requests_sent, results_seen, mismatches, cycle_count);
    $display("Longest drain %0d slots, %0d overflow drops, %0d sequence wraps, %0d hold-offs",
             longest_drain, overflow_drops, wrap_count, holds_done);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### files.f
sv/srb_pkg.sv
sv/srb_if.sv
sv/srb_ram.sv
sv/srb_ctrl.sv
sv/srb_dp.sv
sv/sequence_reorder_buffer_core.sv
sv/srb_checker.sv
sim/tb_top.sv
